@@ hdl/ihs_pkg.sv @@
// Shared constants, payload types and job types for the integral histogram stream.
package ihs_pkg;

    localparam int PixW        = 8;
    localparam int CfgW        = 12;
    localparam int WidthReset  = 640;
    localparam int MaxWidthDef = 2048;

    localparam int Bins      = 32;
    localparam int BinShift  = 3;
    localparam int BinW      = $clog2(Bins);
    localparam int Bpr       = 8;
    localparam int BprW      = $clog2(Bpr);
    localparam int Groups    = Bins / Bpr;
    localparam int GroupW    = $clog2(Groups);
    localparam int OutGroupW = 2;

    localparam int RowW   = 12;
    localparam int RowMax = 4095;
    localparam int CntW   = 23;
    localparam int CumMax = 4194304;

    localparam int JobDepth = 4;
    localparam int ResDepth = 4;
    localparam int LevW     = $clog2(ResDepth + 1);

    typedef struct packed {
        logic [PixW-1:0] pixel;
        logic            frame_start;
    } t_in;

    typedef struct packed {
        logic [OutGroupW-1:0] bin_group;
        logic [CntW-1:0]      count_a;
        logic [CntW-1:0]      count_b;
        logic [CntW-1:0]      count_c;
        logic [CntW-1:0]      count_d;
        logic [CntW-1:0]      count_e;
        logic [CntW-1:0]      count_f;
        logic [CntW-1:0]      count_g;
        logic [CntW-1:0]      count_h;
        logic                 last_of_pixel;
    } t_out;

    typedef struct packed {
        logic first_row;
        logic clear_row;
    } t_job_ctl;

    typedef logic [Bpr-1:0][CntW-1:0] t_cnt_row;

endpackage

@@ hdl/integral_histogram_stream.sv @@
// A pixel passes the job queue, the back end's stage-1 register and the result queue before its first
// group can be popped. Groups issue at one per cycle while the result queue has room, set by the line
// store port that reads and writes one row of eight cumulative counts per cycle.
// Reset: synchronous, active low; clears queues, column and row counts, sets the first-row flag
//   and sets the width to 640. The line store is not cleared: the first row ignores what it reads.
module integral_histogram_stream import ihs_pkg::*; #(
    parameter int MAX_WIDTH = MaxWidthDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // pixel transactions in
    input  logic            push,
    output logic            full,
    input  t_in             i_in_data,
    // result transactions out, four per pixel
    output logic            empty,
    input  logic            pop,
    output t_out            o_out_data,
    // width register write
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CfgW-1:0] i_cfg_data
);

    localparam int ColW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int JobW    = BinW + ColW + $bits(t_job_ctl);
    localparam int ResW    = $bits(t_out);
    localparam int JobLevW = $clog2(JobDepth + 1);

    logic            w_accept;
    logic [BinW-1:0] w_f_bin;
    logic [ColW-1:0] w_f_col;
    t_job_ctl        w_f_ctl;

    logic [JobW-1:0]    w_job_q;
    logic               w_job_empty;
    logic               w_job_pop;
    logic [JobLevW-1:0] w_job_level;
    logic [BinW-1:0]    w_b_bin;
    logic [ColW-1:0]    w_b_col;
    t_job_ctl           w_b_ctl;

    logic            w_res_push;
    t_out            w_res_data;
    logic            w_res_full;
    logic [LevW-1:0] w_res_level;
    logic [ResW-1:0] w_res_q;

    // The width register is always writable; the user must write it only while idle, the block does not enforce it.
    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !full;

    // Front: classify each pixel into bin, column and row flags.
    ihs_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_in        (i_in_data),
        .o_job_bin   (w_f_bin),
        .o_job_col   (w_f_col),
        .o_job_ctl   (w_f_ctl)
    );

    // Job queue decouples pixel intake from the group sequencer, which issues each job's four groups in turn.
    ihs_fifo #(
        .WIDTH (JobW),
        .DEPTH (JobDepth)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({w_f_bin, w_f_col, w_f_ctl}),
        .o_full  (full),
        .i_pop   (w_job_pop),
        .o_empty (w_job_empty),
        .o_data  (w_job_q),
        .o_level (w_job_level)
    );

    assign {w_b_bin, w_b_col, w_b_ctl} = w_job_q;

    // Back: update row counts, read the row above, add, saturate, write back.
    ihs_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_job_empty),
        .i_job_bin   (w_b_bin),
        .i_job_col   (w_b_col),
        .i_job_ctl   (w_b_ctl),
        .o_job_pop   (w_job_pop),
        .i_res_level (w_res_level),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_data)
    );

    // Result queue holds finished groups while the consumer stalls.
    ihs_fifo #(
        .WIDTH (ResW),
        .DEPTH (ResDepth)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_q),
        .o_level (w_res_level)
    );

    assign o_out_data = t_out'(w_res_q);

    // The sequencer reserves queue space, so a finished group is never dropped.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result queue overflow");

    // A job leaves the queue only when one is present.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> !w_job_empty)
        else $error("job queue underflow");

    // The job queue never holds more than its depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_level <= JobLevW'(JobDepth))
        else $error("job queue level out of range");

    // The last flag marks exactly the final group of a pixel.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_data.last_of_pixel ==
                    (o_out_data.bin_group == OutGroupW'(Groups - 1))))
        else $error("last flag out of step with group");

    // Groups of a pixel go out in order: after a non-final group comes the next one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && !w_res_data.last_of_pixel) |=>
            (w_res_data.bin_group == $past(w_res_data.bin_group) + 1'b1) || !w_res_push)
        else $error("group sequence broken");

endmodule

@@ hdl/ihs_fifo.sv @@
// Small synchronous queue with level output.
module ihs_fifo import ihs_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [WIDTH-1:0]             o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_level
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW   = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [LW-1:0]    r_level;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_level == LW'(DEPTH));
    assign o_empty = (r_level == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_level <= r_level + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

@@ hdl/ihs_front.sv @@
// Front end: width register, column tracking and classification of each pixel.
module ihs_front import ihs_pkg::*; #(
    parameter int MAX_WIDTH = MaxWidthDef
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_valid,
    input  logic [CfgW-1:0]                               i_cfg_data,
    input  logic                                          i_accept,
    input  t_in                                           i_in,
    output logic [BinW-1:0]                               o_job_bin,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_job_col,
    output t_job_ctl                                      o_job_ctl
);

    localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CmpW = (ColW + 1 > CfgW) ? ColW + 1 : CfgW;

    logic [CfgW-1:0] r_width;
    logic [ColW-1:0] r_col;
    logic            r_first_row;
    logic            r_clear_pend;

    logic [ColW-1:0] w_col;
    logic            w_first;
    logic [CmpW-1:0] w_w_ext;
    logic [CmpW-1:0] w_eff;
    logic [CmpW-1:0] w_col_nx;
    logic            w_row_end;

    // A frame start restarts the column and the first-row flag before counting.
    assign w_col   = i_in.frame_start ? '0 : r_col;
    assign w_first = i_in.frame_start ? 1'b1 : r_first_row;

    // Width zero acts as one, width above the line store is clamped.
    assign w_w_ext = CmpW'(r_width);
    always_comb begin
        if (w_w_ext == '0) begin
            w_eff = CmpW'(1);
        end else if (w_w_ext > CmpW'(MAX_WIDTH)) begin
            w_eff = CmpW'(MAX_WIDTH);
        end else begin
            w_eff = w_w_ext;
        end
    end

    assign w_col_nx  = CmpW'(w_col) + CmpW'(1);
    assign w_row_end = (w_col_nx >= w_eff);

    assign o_job_bin           = BinW'(i_in.pixel >> BinShift);
    assign o_job_col           = w_col;
    assign o_job_ctl.first_row = w_first;
    assign o_job_ctl.clear_row = i_in.frame_start || r_clear_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= CfgW'(WidthReset);
            r_col        <= '0;
            r_first_row  <= 1'b1;
            r_clear_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_cfg_data;
            end
            if (i_accept) begin
                r_col        <= w_row_end ? '0 : w_col_nx[ColW-1:0];
                r_first_row  <= w_row_end ? 1'b0 : w_first;
                r_clear_pend <= w_row_end;
            end
        end
    end

endmodule

@@ hdl/ihs_back.sv @@
// Back end: row bin counts, line store and per-group cumulative sums.
module ihs_back import ihs_pkg::*; #(
    parameter int MAX_WIDTH = MaxWidthDef
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_job_valid,
    input  logic [BinW-1:0]                               i_job_bin,
    input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] i_job_col,
    input  t_job_ctl                                      i_job_ctl,
    output logic                                          o_job_pop,
    input  logic [LevW-1:0]                               i_res_level,
    output logic                                          o_res_push,
    output t_out                                          o_res_data
);

    localparam int ColW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AddrW   = ColW + GroupW;
    localparam int MemRows = MAX_WIDTH * Groups;

    t_cnt_row         r_mem [MemRows];
    t_cnt_row         r_rdata;
    logic [RowW-1:0]  r_row_cnt [Bins];
    logic [RowW-1:0]  n_row_cnt [Bins];
    logic [GroupW-1:0] r_g;
    logic             r_s1_valid;
    logic [AddrW-1:0] r_s1_addr;
    logic [GroupW-1:0] r_s1_g;
    logic             r_s1_first_row;

    logic             w_room;
    logic             w_issue;
    logic             w_start;
    logic             w_last;
    logic [AddrW-1:0] w_rd_addr;
    t_cnt_row         w_sum;

    // Issue only when the result queue can take this group and the one in flight.
    assign w_room    = (LevW'(1) + i_res_level + LevW'(r_s1_valid)) <= LevW'(ResDepth);
    assign w_issue   = i_job_valid && w_room;
    assign w_start   = w_issue && (r_g == '0);
    assign w_last    = (r_g == GroupW'(Groups - 1));
    assign o_job_pop = w_issue && w_last;
    assign w_rd_addr = {i_job_col, r_g};

    // Clear the row, then count the pixel, when its first group issues.
    always_comb begin
        logic [RowW-1:0] base;
        for (int k = 0; k < Bins; k++) begin
            base = (w_start && i_job_ctl.clear_row) ? '0 : r_row_cnt[k];
            if (w_start && (i_job_bin == BinW'(k)) && (base != RowW'(RowMax))) begin
                n_row_cnt[k] = base + 1'b1;
            end else begin
                n_row_cnt[k] = base;
            end
        end
    end

    always_comb begin
        logic [BinW-1:0] idx;
        logic [CntW-1:0] above;
        logic [CntW:0]   sum;
        for (int j = 0; j < Bpr; j++) begin
            idx   = {r_s1_g, BprW'(j)};
            above = r_s1_first_row ? '0 : r_rdata[j];
            sum   = (CntW + 1)'(above) + (CntW + 1)'(r_row_cnt[idx]);
            w_sum[j] = (sum > (CntW + 1)'(CumMax)) ? CntW'(CumMax) : sum[CntW-1:0];
        end
    end

    assign o_res_push               = r_s1_valid;
    assign o_res_data.bin_group     = OutGroupW'(r_s1_g);
    assign o_res_data.count_a       = w_sum[0];
    assign o_res_data.count_b       = w_sum[1];
    assign o_res_data.count_c       = w_sum[2];
    assign o_res_data.count_d       = w_sum[3];
    assign o_res_data.count_e       = w_sum[4];
    assign o_res_data.count_f       = w_sum[5];
    assign o_res_data.count_g       = w_sum[6];
    assign o_res_data.count_h       = w_sum[7];
    assign o_res_data.last_of_pixel = (r_s1_g == GroupW'(Groups - 1));

    // Line store: one row of eight counts read and one written per cycle.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rdata <= r_mem[w_rd_addr];
        end
        if (r_s1_valid) begin
            r_mem[r_s1_addr] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_addr      <= w_rd_addr;
            r_s1_g         <= r_g;
            r_s1_first_row <= i_job_ctl.first_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g        <= '0;
            r_s1_valid <= 1'b0;
            for (int k = 0; k < Bins; k++) begin
                r_row_cnt[k] <= '0;
            end
        end else begin
            r_s1_valid <= w_issue;
            if (w_issue) begin
                r_g <= w_last ? '0 : r_g + 1'b1;
            end
            for (int k = 0; k < Bins; k++) begin
                r_row_cnt[k] <= n_row_cnt[k];
            end
        end
    end

endmodule

@@ bench/integral_histogram_stream_test.sv @@
// Self-checking bench for the integral histogram stream: random pixels, width changes, queued results.
module integral_histogram_stream_test;
    import ihs_pkg::*;

    localparam int CycleLimit = 400000;

    // Stimulus entries: a pixel transaction or a width register write.
    typedef enum logic {
        ENTRY_PIXEL,
        ENTRY_WIDTH
    } t_entry_kind;

    typedef struct packed {
        t_entry_kind     kind;
        t_in             px;
        logic [CfgW-1:0] width;
    } t_stim;

    logic            i_clk;
    logic            i_rst_n;
    logic            push;
    logic            full;
    t_in             i_in_data;
    logic            empty;
    logic            pop;
    t_out            o_out_data;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [CfgW-1:0] i_cfg_data;

    integral_histogram_stream uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_data   (i_in_data),
        .empty       (empty),
        .pop         (pop),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Stimulus still to drive, filled once at time zero.
    t_stim pending[$];
    // Result groups predicted but not yet popped, oldest first.
    t_out  hist_expect[$];

    // Predicted block state.
    logic [CfgW-1:0] width_reg;
    logic [RowW-1:0] row_count [Bins];
    logic [CntW-1:0] line_hist [MaxWidthDef * Bins];
    int unsigned     col_index;
    bit              top_row;

    int pixels_sent;      // pixel transactions accepted so far (driver side)
    int results_checked;  // result transactions popped so far (monitor side)
    int mismatches;
    int cycles;
    bit stim_done;

    // Width zero acts as one; anything past the line store is clamped to it.
    function automatic int unsigned effective_width(input logic [CfgW-1:0] w);
        if (w == 0)
            return 1;
        if (w > MaxWidthDef)
            return MaxWidthDef;
        return 32'(w);
    endfunction

    // Count one pixel into its bin, build its cumulative histogram from the row
    // above plus the running row counts, write it back and queue its four groups.
    task automatic accumulate_pixel(input t_in px);
        int unsigned     c;
        int unsigned     b;
        int unsigned     s;
        int unsigned     above;
        logic [CntW-1:0] cum [Bins];
        t_out            grp;
        if (px.frame_start) begin
            col_index = 0;
            top_row   = 1'b1;
            foreach (row_count[k]) row_count[k] = '0;
        end
        c = col_index;
        if (c >= MaxWidthDef)
            c = MaxWidthDef - 1;
        b = 32'(px.pixel) >> BinShift;
        if (row_count[b] < RowMax)
            row_count[b] = row_count[b] + 1'b1;
        for (int k = 0; k < Bins; k++) begin
            above = top_row ? 0 : line_hist[c * Bins + k];
            s = above + row_count[k];
            if (s > CumMax)
                s = CumMax;
            cum[k] = CntW'(s);
            line_hist[c * Bins + k] = CntW'(s);
        end
        // Close the row once the column reaches the current width.
        if (c + 1 >= effective_width(width_reg)) begin
            col_index = 0;
            top_row   = 1'b0;
            foreach (row_count[k]) row_count[k] = '0;
        end else begin
            col_index = c + 1;
        end
        for (int g = 0; g < Groups; g++) begin
            grp.bin_group     = OutGroupW'(g);
            grp.count_a       = cum[g * Bpr + 0];
            grp.count_b       = cum[g * Bpr + 1];
            grp.count_c       = cum[g * Bpr + 2];
            grp.count_d       = cum[g * Bpr + 3];
            grp.count_e       = cum[g * Bpr + 4];
            grp.count_f       = cum[g * Bpr + 5];
            grp.count_g       = cum[g * Bpr + 6];
            grp.count_h       = cum[g * Bpr + 7];
            grp.last_of_pixel = (g == Groups - 1);
            hist_expect.push_back(grp);
        end
    endtask

    task automatic check_field(input string name, input logic [CntW-1:0] want,
                               input logic [CntW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_width(input int w);
        t_stim st;
        st.kind  = ENTRY_WIDTH;
        st.px    = '0;
        st.width = CfgW'(w);
        pending.push_back(st);
    endtask

    task automatic queue_pixel(input int p, input bit fs);
        t_stim st;
        st.kind           = ENTRY_PIXEL;
        st.px.pixel       = PixW'(p);
        st.px.frame_start = fs;
        st.width          = '0;
        pending.push_back(st);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Free-running cycle count; end the run if it ever reaches the limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Driver: feed pixel transactions from the pending queue with random gaps.
    // A width write waits until every predicted result has been popped, so the
    // block is idle whenever the register changes.
    always @(posedge i_clk) begin : drive
        bit accepted;
        bit cfg_done;
        bit calm;
        bit nxt_push;
        bit nxt_cfg;
        int sent_now;
        if (!i_rst_n) begin
            push        <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            accepted = push && !full;
            cfg_done = i_cfg_valid && o_cfg_ready;
            sent_now = pixels_sent + accepted;
            pixels_sent <= sent_now;
            if (cfg_done)
                void'(pending.pop_front());
            if (push && full) begin
                // hold the pixel until the block takes it
            end else if (i_cfg_valid && !o_cfg_ready) begin
                // hold the width write until it lands
            end else begin
                nxt_push = 1'b0;
                nxt_cfg  = 1'b0;
                // Keep a stretch of pixels with no gaps at all.
                calm = (sent_now >= 150) && (sent_now < 300);
                if (pending.size() > 0) begin
                    if (pending[0].kind == ENTRY_PIXEL) begin
                        if (calm || $urandom_range(99) >= 26) begin
                            nxt_push = 1'b1;
                            i_in_data <= pending[0].px;
                            void'(pending.pop_front());
                        end
                    end else if (results_checked == Groups * sent_now) begin
                        nxt_cfg = 1'b1;
                        i_cfg_data <= pending[0].width;
                    end
                end
                push        <= nxt_push;
                i_cfg_valid <= nxt_cfg;
                if (pending.size() == 0 && !nxt_push && !nxt_cfg)
                    stim_done <= 1'b1;
            end
        end
    end

    // Monitor: check each popped group against the oldest prediction, then
    // advance the predictor with whatever transaction the edge carried.
    always @(posedge i_clk) begin : watch
        t_out want;
        bit   calm;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_checked <= results_checked + 1;
                if (hist_expect.size() == 0) begin
                    $error("result popped with no prediction waiting: group %0d",
                           o_out_data.bin_group);
                    mismatches++;
                end else begin
                    want = hist_expect.pop_front();
                    check_field("bin_group", CntW'(want.bin_group),
                                CntW'(o_out_data.bin_group));
                    check_field("count_a", want.count_a, o_out_data.count_a);
                    check_field("count_b", want.count_b, o_out_data.count_b);
                    check_field("count_c", want.count_c, o_out_data.count_c);
                    check_field("count_d", want.count_d, o_out_data.count_d);
                    check_field("count_e", want.count_e, o_out_data.count_e);
                    check_field("count_f", want.count_f, o_out_data.count_f);
                    check_field("count_g", want.count_g, o_out_data.count_g);
                    check_field("count_h", want.count_h, o_out_data.count_h);
                    check_field("last_of_pixel", CntW'(want.last_of_pixel),
                                CntW'(o_out_data.last_of_pixel));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                width_reg = i_cfg_data;
            if (push && !full)
                accumulate_pixel(i_in_data);
            calm = (results_checked >= 1000) && (results_checked < 1500);
            pop <= calm || ($urandom_range(99) >= 26);
        end
    end

    initial begin : stimulus
        int          random_pixels;
        int          n;
        int          w;
        int          roll;
        int unsigned gen_eff;
        int unsigned eff_new;
        bit          fs_first;
        bit          fs;
        logic [BinW-1:0] hot [4];
        logic [PixW-1:0] p;

        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        pop         <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        pixels_sent     <= 0;
        results_checked <= 0;
        mismatches      = 0;
        cycles          <= 0;
        stim_done       <= 1'b0;

        // Predictor reset: width 640, first row, empty row counts.
        width_reg = CfgW'(WidthReset);
        col_index = 0;
        top_row   = 1'b1;
        foreach (row_count[k]) row_count[k] = '0;

        // Directed: bin edges on the first row after reset, then a frame start mid-row.
        queue_pixel(0, 0);
        queue_pixel(255, 0);
        queue_pixel(7, 0);
        queue_pixel(8, 0);
        queue_pixel(248, 0);
        queue_pixel(128, 1);
        // Width zero: every pixel is a row of its own.
        queue_width(0);
        queue_pixel(3, 1);
        queue_pixel(3, 0);
        queue_pixel(250, 0);
        queue_pixel(3, 0);
        // Width past the line store clamps; then shrink it mid first row.
        queue_width(4095);
        queue_pixel(16, 1);
        queue_pixel(17, 0);
        queue_pixel(100, 0);
        queue_pixel(200, 0);
        queue_pixel(31, 0);
        queue_pixel(255, 0);
        queue_width(3);
        queue_pixel(64, 0);
        queue_pixel(65, 0);
        queue_pixel(66, 0);
        queue_pixel(67, 0);
        queue_pixel(0, 0);
        queue_pixel(255, 0);
        queue_pixel(128, 0);
        queue_pixel(9, 0);
        // Shrink again on a later row with the column already past the new width.
        queue_width(1);
        queue_pixel(10, 0);
        queue_pixel(11, 0);
        queue_width(2048);
        queue_pixel(77, 1);
        queue_pixel(200, 0);
        gen_eff = MaxWidthDef;

        // Random phases: mostly narrow frames that run many rows deep.
        random_pixels = 0;
        while (random_pixels < 420) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
                roll = $urandom_range(99);
                if (roll < 70)
                    w = $urandom_range(1, 24);
                else if (roll < 82)
                    w = $urandom_range(25, 200);
                else if (roll < 90)
                    w = 0;
                else if (roll < 95)
                    w = $urandom_range(MaxWidthDef, 4095);
                else
                    w = $urandom_range(201, MaxWidthDef - 1);
                eff_new = effective_width(CfgW'(w));
                queue_width(w);
                // Growing the width mid-frame would read unwritten columns:
                // open a new frame whenever it grows.
                fs_first = (eff_new > gen_eff) || ($urandom_range(1) == 1);
                gen_eff  = eff_new;
            end else begin
                fs_first = ($urandom_range(1) == 1);
            end
            n = (gen_eff <= 24) ? $urandom_range(1, 3 * gen_eff + 4) : $urandom_range(1, 16);
            foreach (hot[k]) hot[k] = BinW'($urandom_range(Bins - 1));
            for (int i = 0; i < n; i++) begin
                fs = (i == 0) ? fs_first : ($urandom_range(99) < 3);
                if ($urandom_range(1) == 1)
                    p = PixW'($urandom_range(255));
                else
                    p = {hot[$urandom_range(3)], 3'($urandom_range(7))};
                queue_pixel(p, fs);
                random_pixels++;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all stimulus sent and every predicted group popped, then settle.
        wait (stim_done && results_checked == Groups * pixels_sent);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        if (hist_expect.size() != 0) begin
            $error("%0d predicted groups never arrived", hist_expect.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ihs_pkg.sv
hdl/ihs_fifo.sv
hdl/ihs_front.sv
hdl/ihs_back.sv
hdl/integral_histogram_stream.sv
bench/integral_histogram_stream_test.sv
